FILE: design/icr_pkg.sv
// Package with widths, constants and the cell state type for the integer cube root.
`timescale 1ns / 1ps
package icr_pkg;

	// Input word width the root is taken over
	localparam int WORD_BITS = 64;
	// Fixed widths of the transfer fields
	localparam int VALUE_W   = 64;
	localparam int ROOT_W    = 22;
	// One root bit per three-bit group of the input word
	localparam int STEPS     = (WORD_BITS + 2) / 3;
	localparam int PAD_W     = 3 * STEPS;
	// Square of the partial root, and partial remainder with headroom for the group shift
	localparam int SQ_W      = 2 * ROOT_W;
	localparam int REM_W     = 2 * ROOT_W + 4;
	// Largest root of a 64-bit word
	localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(2642245);

	// State handed from one cell to the next
	typedef struct packed {
		logic [PAD_W-1:0] x;    // input bits not yet consumed, next group at the top
		logic [REM_W-1:0] rem;  // partial remainder
		logic [ROOT_W-1:0] y;   // partial root
		logic [SQ_W-1:0] sq;    // y * y
	} icr_cell_t;

endpackage

FILE: design/icr_if.sv
// Valid/ready channel interfaces for the operand and result transfers.
`timescale 1ns / 1ps
interface icr_operand_if;
	import icr_pkg::*;
	logic valid;
	logic ready;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface icr_result_if;
	import icr_pkg::*;
	logic valid;
	logic ready;
	logic [ROOT_W-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink (input valid, input root, output ready);
endinterface

FILE: design/icr_cell.sv
// One restoring cube root cell: settles one root bit from the next three input bits.
`timescale 1ns / 1ps
module icr_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              vld_in,
	input  icr_pkg::icr_cell_t st_in,
	output logic              vld_out,
	output icr_pkg::icr_cell_t st_out
);
	import icr_pkg::*;

	logic [2:0]        grp;
	logic [REM_W-1:0]  rem_sh;
	logic [ROOT_W-1:0] y2;
	logic [SQ_W-1:0]   sq4;
	logic [REM_W-1:0]  trial;
	logic              fits;
	icr_cell_t         st_d;
	icr_cell_t         st_q;
	logic              vld_q;

	// Bring down the next group and form the trial subtrahend 3*y2*(y2+1)+1
	always_comb begin
		grp    = st_in.x[PAD_W-1 -: 3];
		rem_sh = {st_in.rem[REM_W-4:0], grp};
		y2     = {st_in.y[ROOT_W-2:0], 1'b0};
		sq4    = {st_in.sq[SQ_W-3:0], 2'b00};
		trial  = REM_W'(sq4) + {REM_W'(sq4)} + {REM_W'(sq4)}
			+ REM_W'(y2) + REM_W'(y2) + REM_W'(y2) + REM_W'(1);
		fits   = rem_sh >= trial;
	end

	// Subtract when the trial fits and set the new root bit
	always_comb begin
		st_d.x   = {st_in.x[PAD_W-4:0], 3'b000};
		st_d.rem = fits ? (rem_sh - trial) : rem_sh;
		st_d.y   = {y2[ROOT_W-1:1], fits};
		st_d.sq  = fits ? (sq4 + SQ_W'(y2) + SQ_W'(y2) + SQ_W'(1)) : sq4;
	end

	// Hold the cell valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	// Advance the payload
	always_ff @(posedge clk) begin
		if (adv) begin
			st_q <= st_d;
		end
	end

	assign vld_out = vld_q;
	assign st_out  = st_q;

endmodule

FILE: design/integer_cube_root.sv
// Each operand passes through the row of registered root-bit cells, one cell per root bit, to result valid.
// Throughput: one item per cycle while the result side takes transfers; the row of
// root-bit cells advances as a whole and stalls only when the last result is held.
// Each cell settles one root bit with a wide trial sum, a compare and a conditional subtract.
// Reset: arst_n clears every cell valid flag at once; payload registers are not reset.
`timescale 1ns / 1ps
module integer_cube_root (
	input  logic             clk,
	input  logic             arst_n,
	icr_operand_if.sink      operand,
	icr_result_if.source     result
);
	import icr_pkg::*;

	logic      adv;
	logic      vld [0:STEPS];
	icr_cell_t st  [0:STEPS];

	// Move the whole row when the last cell is empty or its result is taken
	assign adv = !vld[STEPS] || result.ready;
	assign operand.ready = adv;

	// Seed the first cell with the masked input word
	always_comb begin
		vld[0]    = operand.valid;
		st[0].x   = PAD_W'(operand.value[WORD_BITS-1:0]);
		st[0].rem = '0;
		st[0].y   = '0;
		st[0].sq  = '0;
	end

	// Row of root-bit cells
	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		icr_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.vld_in  (vld[i]),
			.st_in   (st[i]),
			.vld_out (vld[i+1]),
			.st_out  (st[i+1])
		);
	end

	assign result.valid = vld[STEPS];
	assign result.root  = st[STEPS].y;

`ifndef SYNTHESIS
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.root <= ROOT_MAX)
		else $error("root out of range");

	a_sq_track: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> st[STEPS].sq == SQ_W'(SQ_W'(st[STEPS].y) * SQ_W'(st[STEPS].y)))
		else $error("square register out of step with root");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> st[STEPS].rem <= REM_W'(3) * REM_W'(st[STEPS].sq)
			+ REM_W'(3) * REM_W'(st[STEPS].y))
		else $error("remainder exceeds restoring bound");
`endif

endmodule

FILE: test/tb.sv
// Self-checking testbench for the integer cube root over valid/ready transfers.
`timescale 1ns / 1ps
module tb;
	import icr_pkg::*;

	localparam int RANDOM_ITEMS = 600;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 40;
	localparam logic [VALUE_W-1:0] ALL_ONES   = {VALUE_W{1'b1}};
	localparam logic [VALUE_W-1:0] CUBE_OF_MAX = 64'd18446724184312856125;

	// One directed probe: operand, and a typed root where it is obvious
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               typed;
		logic [ROOT_W-1:0]  root;
	} probe_t;

	localparam int DIRECTED_COUNT = 22;
	localparam probe_t DIRECTED [0:DIRECTED_COUNT-1] = '{
		'{64'd0, 1'b1, ROOT_W'(0)},
		'{64'd1, 1'b1, ROOT_W'(1)},
		'{ALL_ONES, 1'b1, ROOT_MAX},
		'{CUBE_OF_MAX, 1'b1, ROOT_MAX},
		'{CUBE_OF_MAX - 64'd1, 1'b0, ROOT_W'(0)},
		'{CUBE_OF_MAX + 64'd1, 1'b0, ROOT_W'(0)},
		'{64'd7, 1'b0, ROOT_W'(0)},
		'{64'd8, 1'b0, ROOT_W'(0)},
		'{64'd26, 1'b0, ROOT_W'(0)},
		'{64'd27, 1'b0, ROOT_W'(0)},
		'{64'd63, 1'b0, ROOT_W'(0)},
		'{64'd64, 1'b0, ROOT_W'(0)},
		'{64'd999, 1'b0, ROOT_W'(0)},
		'{64'd1000, 1'b0, ROOT_W'(0)},
		'{64'h8000_0000_0000_0000, 1'b0, ROOT_W'(0)},
		'{64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ROOT_W'(0)},
		'{64'h5555_5555_5555_5555, 1'b0, ROOT_W'(0)},
		'{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, ROOT_W'(0)},
		'{64'h0000_0000_FFFF_FFFF, 1'b0, ROOT_W'(0)},
		'{64'hFFFF_FFFF_0000_0000, 1'b0, ROOT_W'(0)},
		'{64'h0000_0000_0000_0002, 1'b0, ROOT_W'(0)},
		'{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, ROOT_W'(0)}
	};

	logic clk;
	logic arst_n;
	logic quiet;
	int mismatch_count;
	int cycle_count;
	logic [ROOT_W-1:0] roots_pending [$];
	logic [ROOT_W-1:0] root_want;

	icr_operand_if operand_ch ();
	icr_result_if  result_ch ();

	integer_cube_root dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand_ch),
		.result  (result_ch)
	);

	always #1 clk = ~clk;

	// Floor of the cube root, restoring method, one root bit per three-bit group
	function automatic logic [ROOT_W-1:0] cube_root_of(logic [VALUE_W-1:0] v);
		logic [63:0] rem;
		logic [63:0] y;
		logic [63:0] b;
		int shift;
		rem = v & (ALL_ONES >> (64 - WORD_BITS));
		y = 64'd0;
		shift = PAD_W - 3;
		while (shift >= 0) begin
			y = y << 1;
			b = 64'd3 * y * (y + 64'd1) + 64'd1;
			if ((rem >> shift) >= b) begin
				rem = rem - (b << shift);
				y = y + 64'd1;
			end
			shift = shift - 3;
		end
		return y[ROOT_W-1:0];
	endfunction

	// Idle length: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random operand: full words, narrowed words, cubes and their neighbors, low runs of ones, bit walks
	function automatic logic [VALUE_W-1:0] random_operand();
		logic [VALUE_W-1:0] v;
		logic [63:0] r;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 4))
			0: ;
			1: v = v >> $urandom_range(0, 63);
			2: begin
				r = 64'($urandom_range(0, 2642245));
				v = r * r * r + 64'($urandom_range(0, 2)) - 64'd1;
			end
			3: v = ALL_ONES >> $urandom_range(0, 63);
			default: v = 64'd1 << $urandom_range(0, 63);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s, got %0d, want %0d", cycle_count, what, got, want);
		mismatch_count++;
	endtask

	// Hold the operand until the transfer, then queue its expected root
	task automatic send_operand(logic [VALUE_W-1:0] v, logic typed, logic [ROOT_W-1:0] root);
		operand_ch.valid <= 1'b1;
		operand_ch.value <= v;
		@(posedge clk);
		while (!operand_ch.ready)
			@(posedge clk);
		roots_pending.push_back(typed ? root : cube_root_of(v));
	endtask

	task automatic idle_operand();
		int gap;
		gap = quiet ? 0 : idle_len();
		if (gap > 0) begin
			operand_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Bound the run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

	// Stall the result side in random stretches
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = quiet ? 0 : idle_len();
			if (hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Check each result transfer against the oldest pending root
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (roots_pending.size() == 0) begin
				report_mismatch("result transfer with nothing pending", 64'(result_ch.root), 64'd0);
			end else begin
				root_want = roots_pending.pop_front();
				if (result_ch.root !== root_want)
					report_mismatch("root", 64'(result_ch.root), 64'(root_want));
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		mismatch_count = 0;
		operand_ch.valid = 1'b0;
		operand_ch.value = '0;
		result_ch.ready = 1'b0;

		// Hold reset, then release on an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			idle_operand();
			send_operand(DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].root);
		end

		// Random operands, with a stretch of back-to-back transfers in the middle
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet = (i >= 250 && i < 350);
			idle_operand();
			send_operand(random_operand(), 1'b0, ROOT_W'(0));
		end
		quiet = 1'b0;
		operand_ch.valid <= 1'b0;

		// Drain, then watch for stray results
		while (roots_pending.size() != 0)
			@(posedge clk);
		repeat (STEPS + 10) @(posedge clk);
		if (roots_pending.size() != 0)
			report_mismatch("roots left pending", 64'(roots_pending.size()), 64'd0);

		if (mismatch_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

FILE: files.f
design/icr_pkg.sv
design/icr_if.sv
design/icr_cell.sv
design/integer_cube_root.sv
test/tb.sv
